@@ src/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
package spq_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT   = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_PEEK     = 3'd2,
		CMD_CONTAINS = 3'd3,
		CMD_ERASE    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_EMPTY     = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

	// Operation applied to every cell of the chain at once.
	typedef struct packed {
		logic clear;
		logic insert;
		logic remove;
		logic search;
	} chain_ctrl_t;

	localparam int LIMIT_W = 5;
	localparam int COUNT_OUT_W = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_LENGTH_LIMIT = 1'b0;

endpackage

@@ src/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: handshake control, register port and cell chain.
//
// Commands arrive as beats on the input channel (in_valid / in_stall) with command,
// key and payload; every command yields exactly one result beat on the output channel
// (out_valid / out_stall) carrying status, out_key, out_payload and entry_count.
// Entries live in a row of CAPACITY cells kept sorted by key, highest key in front;
// equal keys leave in arrival order. Insert, remove and erase update every cell in
// the same cycle, and contains compares all cells at once.
// An accepted beat runs through an execute state, in which the chain updates and the
// per-cell match flags are registered, and a finish state that folds the match flags
// and loads the output register, which then holds the valid result beat. The block
// takes no new command until the finish state has loaded that register.
// The input is stalled while a command is in flight. A result waiting in the output
// register does not block the next command; only the finish cycle waits for it.
// The length_limit register (byte address 0 of the APB port) caps the entry count;
// zero means only CAPACITY applies. Write it only while the block is idle.
// Reset empties the queue, clears length_limit and drops any pending result beat.
module sorted_priority_queue #(
	parameter int CAPACITY = 16,
	parameter int KEY_WIDTH = 16,
	parameter int PAYLOAD_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [spq_pkg::PADDR_W-1:0]        paddr,
	input  logic [spq_pkg::PDATA_W-1:0]        pwdata,
	output logic [spq_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         command,
	input  logic [KEY_WIDTH-1:0]               key,
	input  logic [PAYLOAD_WIDTH-1:0]           payload,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [KEY_WIDTH-1:0]               out_key,
	output logic [PAYLOAD_WIDTH-1:0]           out_payload,
	output logic [spq_pkg::COUNT_OUT_W-1:0]    entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > spq_pkg::LIMIT_W) ? CW : spq_pkg::LIMIT_W;

	spq_pkg::state_t state_q, state_d;

	logic [spq_pkg::LIMIT_W-1:0] limit_q;
	logic [CW-1:0]               count_q;
	logic [2:0]                  cmd_q;
	logic [KEY_WIDTH-1:0]        key_q;
	logic [PAYLOAD_WIDTH-1:0]    payload_q;

	// Result fields settled in the execute cycle.
	logic [1:0]               res_status_q;
	logic [KEY_WIDTH-1:0]     res_key_q;
	logic [PAYLOAD_WIDTH-1:0] res_payload_q;

	// Output register.
	logic                               out_valid_q;
	logic [1:0]                         out_status_q;
	logic [KEY_WIDTH-1:0]               out_key_q;
	logic [PAYLOAD_WIDTH-1:0]           out_payload_q;
	logic [spq_pkg::COUNT_OUT_W-1:0]    out_count_q;

	spq_pkg::chain_ctrl_t     ctrl;
	logic [KEY_WIDTH-1:0]     head_key;
	logic [PAYLOAD_WIDTH-1:0] head_payload;
	logic [CAPACITY-1:0]      valid_vec;
	logic                     found;

	logic in_accept;
	logic out_free;
	logic load_out;
	logic cfg_write;
	logic full;
	logic empty;
	logic [1:0] fin_status;

	// Register port. Only the word at byte addresses 0 to 3 (paddr[2] low) holds a register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == spq_pkg::REG_LENGTH_LIMIT) ?
		spq_pkg::PDATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_write && paddr[2] == spq_pkg::REG_LENGTH_LIMIT) begin
			limit_q <= pwdata[spq_pkg::LIMIT_W-1:0];
		end
	end

	// The store is full at capacity, or at a nonzero limit (a limit above
	// capacity never binds before capacity does).
	assign empty = (count_q == '0);
	assign full  = (count_q >= CW'(CAPACITY)) ||
		((limit_q != '0) && (CMPW'(count_q) >= CMPW'(limit_q)));

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = spq_pkg::ST_EXEC;
				end
			end
			spq_pkg::ST_EXEC: begin
				state_d = spq_pkg::ST_FIN;
			end
			spq_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = spq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spq_pkg::ST_IDLE;
			end
		endcase
	end

	// State-dependent outputs: input stall, chain operation and output load.
	always_comb begin
		in_stall    = 1'b1;
		ctrl        = '0;
		load_out    = 1'b0;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			spq_pkg::ST_EXEC: begin
				ctrl.insert = (cmd_q == spq_pkg::CMD_INSERT) && !full;
				ctrl.remove = (cmd_q == spq_pkg::CMD_REMOVE) && !empty;
				ctrl.clear  = (cmd_q == spq_pkg::CMD_ERASE);
				ctrl.search = (cmd_q == spq_pkg::CMD_CONTAINS);
			end
			spq_pkg::ST_FIN: begin
				load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command capture.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q     <= command;
			key_q     <= key;
			payload_q <= payload;
		end
	end

	// Entry count tracks the chain's valid cells.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.insert) begin
			count_q <= count_q + CW'(1);
		end else if (ctrl.remove) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Status and front entry, taken before the chain shifts.
	always_ff @(posedge clk) begin
		if (state_q == spq_pkg::ST_EXEC) begin
			res_status_q  <= spq_pkg::STS_OK;
			res_key_q     <= '0;
			res_payload_q <= '0;
			case (cmd_q)
				spq_pkg::CMD_INSERT: begin
					if (full) begin
						res_status_q <= spq_pkg::STS_FULL;
					end
				end
				spq_pkg::CMD_REMOVE, spq_pkg::CMD_PEEK: begin
					if (empty) begin
						res_status_q <= spq_pkg::STS_EMPTY;
					end else begin
						res_key_q     <= head_key;
						res_payload_q <= head_payload;
					end
				end
				default: begin
					res_status_q <= spq_pkg::STS_OK;
				end
			endcase
		end
	end

	// Contains gets its answer from the registered match flags.
	assign fin_status = (cmd_q == spq_pkg::CMD_CONTAINS) ?
		(found ? spq_pkg::STS_OK : spq_pkg::STS_NOT_FOUND) : res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q  <= fin_status;
			out_key_q     <= res_key_q;
			out_payload_q <= res_payload_q;
			out_count_q   <= spq_pkg::COUNT_OUT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign out_key     = out_key_q;
	assign out_payload = out_payload_q;
	assign entry_count = out_count_q;

	spq_chain #(
		.CAPACITY      (CAPACITY),
		.KEY_WIDTH     (KEY_WIDTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.new_key      (key_q),
		.new_payload  (payload_q),
		.head_key     (head_key),
		.head_payload (head_payload),
		.valid_vec    (valid_vec),
		.found        (found)
	);

	// The valid cells always match the entry count.
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("cell valid bits disagree with entry count");

	// Valid cells form a contiguous block from the front.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + CAPACITY'(1))) == '0)
		else $error("valid cells are not packed at the front");

	// The count never exceeds capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// An accepted command reaches the execute cycle next.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == spq_pkg::ST_EXEC)
		else $error("accepted command did not execute");

	// A finish cycle with a free output register produces a result beat.
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("finished command left no result");

endmodule

@@ src/spq_cell.sv @@
// One cell of the sorted chain: holds a single entry and its valid bit.
module spq_cell #(
	parameter int KEY_WIDTH = 16,
	parameter int PAYLOAD_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_pkg::chain_ctrl_t     ctrl,
	input  logic [KEY_WIDTH-1:0]     new_key,
	input  logic [PAYLOAD_WIDTH-1:0] new_payload,
	input  logic [KEY_WIDTH-1:0]     left_key,
	input  logic [PAYLOAD_WIDTH-1:0] left_payload,
	input  logic                     left_valid,
	input  logic                     left_stay,
	input  logic [KEY_WIDTH-1:0]     right_key,
	input  logic [PAYLOAD_WIDTH-1:0] right_payload,
	input  logic                     right_valid,
	output logic [KEY_WIDTH-1:0]     key,
	output logic [PAYLOAD_WIDTH-1:0] payload,
	output logic                     valid,
	output logic                     stay,
	output logic                     match
);

	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;
	logic                     valid_q;
	logic                     match_q;

	// An entry stays put on insert when its key is equal or higher.
	assign stay = valid_q && (key_q >= new_key);

	always_ff @(posedge clk) begin
		if (ctrl.insert && !stay) begin
			if (left_stay) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end else begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end
		end else if (ctrl.remove) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			// The match flag holds until the next search, so a stalled result keeps it.
			if (ctrl.search) begin
				match_q <= valid_q && (key_q == new_key) && (payload_q == new_payload);
			end
			if (ctrl.clear) begin
				valid_q <= 1'b0;
			end else if (ctrl.insert && !stay) begin
				valid_q <= left_stay ? 1'b1 : left_valid;
			end else if (ctrl.remove) begin
				valid_q <= right_valid;
			end
		end
	end

	assign key     = key_q;
	assign payload = payload_q;
	assign valid   = valid_q;
	assign match   = match_q;

endmodule

@@ src/spq_chain.sv @@
// Row of cells kept in priority order, front entry in cell zero.
module spq_chain #(
	parameter int CAPACITY = 16,
	parameter int KEY_WIDTH = 16,
	parameter int PAYLOAD_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_pkg::chain_ctrl_t     ctrl,
	input  logic [KEY_WIDTH-1:0]     new_key,
	input  logic [PAYLOAD_WIDTH-1:0] new_payload,
	output logic [KEY_WIDTH-1:0]     head_key,
	output logic [PAYLOAD_WIDTH-1:0] head_payload,
	output logic [CAPACITY-1:0]      valid_vec,
	output logic                     found
);

	logic [KEY_WIDTH-1:0]     key_w     [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0] payload_w [CAPACITY];
	logic [CAPACITY-1:0]      stay_w;
	logic [CAPACITY-1:0]      match_w;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_WIDTH-1:0]     l_key;
		logic [PAYLOAD_WIDTH-1:0] l_payload;
		logic                     l_valid;
		logic                     l_stay;
		logic [KEY_WIDTH-1:0]     r_key;
		logic [PAYLOAD_WIDTH-1:0] r_payload;
		logic                     r_valid;

		if (i == 0) begin : g_first
			// The front cell acts as if an entry above it stays.
			assign l_key     = '0;
			assign l_payload = '0;
			assign l_valid   = 1'b0;
			assign l_stay    = 1'b1;
		end else begin : g_mid
			assign l_key     = key_w[i-1];
			assign l_payload = payload_w[i-1];
			assign l_valid   = valid_vec[i-1];
			assign l_stay    = stay_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_key     = '0;
			assign r_payload = '0;
			assign r_valid   = 1'b0;
		end else begin : g_inner
			assign r_key     = key_w[i+1];
			assign r_payload = payload_w[i+1];
			assign r_valid   = valid_vec[i+1];
		end

		spq_cell #(
			.KEY_WIDTH     (KEY_WIDTH),
			.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.new_key       (new_key),
			.new_payload   (new_payload),
			.left_key      (l_key),
			.left_payload  (l_payload),
			.left_valid    (l_valid),
			.left_stay     (l_stay),
			.right_key     (r_key),
			.right_payload (r_payload),
			.right_valid   (r_valid),
			.key           (key_w[i]),
			.payload       (payload_w[i]),
			.valid         (valid_vec[i]),
			.stay          (stay_w[i]),
			.match         (match_w[i])
		);
	end

	assign head_key     = key_w[0];
	assign head_payload = payload_w[0];
	assign found        = |match_w;

endmodule
